>>> sv/nms_pkg.sv
// Shared constants, configuration codes and types of the neighbour mean smoothing core.
package nms_pkg;

    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_COLS_W  = 6;
    localparam int CFG_ROWS_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS    = 1'd1;

    localparam logic [CFG_COLS_W-1:0] FRAME_COLUMNS_RESET = 6'd10;
    localparam logic [CFG_ROWS_W-1:0] FRAME_ROWS_RESET    = 11'd10;

    // Row and column offsets of the eight neighbours of a window centre.
    localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                2'sd0, 2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] NB_DC [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                2'sd1, -2'sd1, 2'sd0, 2'sd1};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_POS,
        ST_DIV_SLOT,
        ST_NEXT_RES,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_MEAN,
        ST_OUT,
        ST_FINISH
    } nms_state_t;

    // Which element a result belongs to, relative to the current input (row, column).
    typedef enum logic [1:0] {
        KIND_UP_LEFT,
        KIND_UP,
        KIND_LEFT,
        KIND_SELF
    } res_kind_t;

endpackage

>>> sv/neighbour_mean_smoothing_core.sv
// Top level of the neighbour mean smoothing core: 3x3 mean, centre excluded, raster stream.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_pixel_value
//  m_      | out       | m_valid / m_ready  | m_neighbour_mean, m_frame_done
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// One element at a time: per result, 8 window reads from the sample RAM, then the shared
// bit-serial divider.
// The first element after a mid-frame size change adds one divider pass to recover
// row and column, plus the ST_DIV_SLOT state for the RAM slot. Reset needs no clearing pass.
// A stalled result holds the sequencer in its output state; the last result of an
// element may wait in the output register while the next element is taken.
module neighbour_mean_smoothing_core
    import nms_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_pixel_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_neighbour_mean,
    output logic                   m_frame_done,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CIDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int TOT_W   = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int POS_W   = (MAX_COLUMNS * MAX_ROWS > 1) ?
                             $clog2(MAX_COLUMNS * MAX_ROWS) : 1;
    localparam int DEPTH   = 2 * MAX_COLUMNS + 2;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int D_W     = $clog2(DEPTH + 1);
    localparam int EW      = D_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + 3;
    localparam int DW      = (SUM_W > POS_W) ? SUM_W : POS_W;
    localparam int VW0     = (D_W > COL_W) ? D_W : COL_W;
    localparam int VW      = (VW0 > 4) ? VW0 : 4;
    localparam int SLOT_K  = POS_W + ADDR_W;
    localparam int MUL_W   = 2 * POS_W + 2;
    localparam int SLOT_W  = POS_W + ADDR_W;
    // ceil(2^SLOT_K / DEPTH): exact quotient by DEPTH for every position
    localparam logic [MUL_W-1:0] SLOT_RECIP =
        MUL_W'(((64'd1 << SLOT_K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    nms_state_t state_reg, state_next;

    logic [CFG_COLS_W-1:0]  frame_columns_reg, frame_columns_next;
    logic [CFG_ROWS_W-1:0]  frame_rows_reg, frame_rows_next;
    logic [POS_W-1:0]       arrived_reg, arrived_next;
    logic [RIDX_W-1:0]      row_reg, row_next;
    logic [CIDX_W-1:0]      col_reg, col_next;
    logic [ADDR_W-1:0]      slot_reg, slot_next;
    logic [POS_W-1:0]       slot_quo_reg, slot_quo_next;
    logic                   track_ok_reg, track_ok_next;
    logic                   last_reg, last_next;
    logic [SAMPLE_BITS-1:0] pix_reg, pix_next;
    res_kind_t              kind_reg, kind_next;
    logic [2:0]             nb_reg, nb_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic                   pipe_pix_reg, pipe_pix_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [3:0]             count_reg, count_next;
    logic                   neg_reg, neg_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_mean_reg, m_mean_next;
    logic                   m_done_reg, m_done_next;

    logic [COL_W-1:0]       cols;
    logic [ROW_W-1:0]       rows;
    logic [TOT_W-1:0]       total;
    logic                   last_pos;
    logic [POS_W-1:0]       pos_sat;
    logic [MUL_W-1:0]       slot_prod;
    logic [SLOT_W-1:0]      slot_fold;
    logic                   i_ge1, j_ge1, last_row, last_col;
    logic                   kind_has;
    logic                   ri, cj;
    logic signed [1:0]      dr, dc;
    logic                   row_ok, col_ok, nb_exists;
    logic [2:0]             rd_e;
    logic [EW-1:0]          rowpart, d_e, slot_e, addr_e;
    logic                   use_pix;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SUM_W-1:0]       sum_mag;
    logic [SAMPLE_BITS-1:0] q_s, mean_val;
    logic                   out_free;

    logic                   ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;

    logic                   div_start, div_done;
    logic [DW-1:0]          div_dividend, div_quot;
    logic [VW-1:0]          div_divisor, div_rem;

    // Frame geometry
    always_comb begin
        if (frame_columns_reg == '0) begin
            cols = COL_W'(1);
        end else if (frame_columns_reg > CFG_COLS_W'(MAX_COLUMNS)) begin
            cols = COL_W'(MAX_COLUMNS);
        end else begin
            cols = COL_W'(frame_columns_reg);
        end
        if (frame_rows_reg == '0) begin
            rows = ROW_W'(1);
        end else if (frame_rows_reg > CFG_ROWS_W'(MAX_ROWS)) begin
            rows = ROW_W'(MAX_ROWS);
        end else begin
            rows = ROW_W'(frame_rows_reg);
        end
        total    = TOT_W'(cols) * TOT_W'(rows);
        last_pos = TOT_W'(arrived_reg) >= total - TOT_W'(1);
        pos_sat  = last_pos ? POS_W'(total - TOT_W'(1)) : arrived_reg;
        i_ge1    = row_reg != '0;
        j_ge1    = col_reg != '0;
        last_row = ROW_W'(row_reg) == rows - ROW_W'(1);
        last_col = COL_W'(col_reg) == cols - COL_W'(1);

        // RAM slot of the current position: position modulo DEPTH
        slot_prod     = MUL_W'(arrived_reg) * SLOT_RECIP;
        slot_quo_next = POS_W'(slot_prod >> SLOT_K);
        slot_fold     = SLOT_W'(arrived_reg) - SLOT_W'(slot_quo_reg) * SLOT_W'(DEPTH);
    end

    // Result selection and neighbour address
    always_comb begin
        case (kind_reg)
            KIND_UP_LEFT: kind_has = i_ge1 && j_ge1;
            KIND_UP:      kind_has = i_ge1 && last_col;
            KIND_LEFT:    kind_has = last_row && j_ge1;
            KIND_SELF:    kind_has = last_row && last_col;
            default:      kind_has = 1'b0;
        endcase
        ri = (kind_reg == KIND_UP_LEFT) || (kind_reg == KIND_UP);
        cj = (kind_reg == KIND_UP_LEFT) || (kind_reg == KIND_LEFT);
        dr = NB_DR[nb_reg];
        dc = NB_DC[nb_reg];

        if (dr < 0) begin
            row_ok = ri ? (row_reg > RIDX_W'(1)) : i_ge1;
        end else if (dr > 0) begin
            row_ok = ri || !last_row;
        end else begin
            row_ok = 1'b1;
        end
        if (dc < 0) begin
            col_ok = cj ? (col_reg > CIDX_W'(1)) : j_ge1;
        end else if (dc > 0) begin
            col_ok = cj || !last_col;
        end else begin
            col_ok = 1'b1;
        end
        nb_exists = row_ok && col_ok;

        rd_e = {2'b00, ri} - {dr[1], dr};
        case (rd_e)
            3'd1:    rowpart = EW'(cols);
            3'd2:    rowpart = EW'({cols, 1'b0});
            default: rowpart = '0;
        endcase
        d_e     = rowpart + EW'(cj) - {{(EW - 2){dc[1]}}, dc};
        use_pix = d_e == '0;
        slot_e  = EW'(slot_reg);
        if (slot_e >= d_e) begin
            addr_e = slot_e - d_e;
        end else begin
            addr_e = slot_e + EW'(DEPTH) - d_e;
        end
    end

    // Accumulation and mean
    always_comb begin
        sample   = pipe_pix_reg ? $signed(pix_reg) : $signed(ram_rd_data);
        sum_mag  = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        q_s      = div_quot[SAMPLE_BITS-1:0];
        if (count_reg == '0) begin
            mean_val = '0;
        end else if (neg_reg) begin
            mean_val = -q_s;
        end else begin
            mean_val = q_s;
        end
        out_free = !m_valid_reg || m_ready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = track_ok_reg ? ST_NEXT_RES : ST_DIV_POS;
            end
            ST_DIV_POS: begin
                if (div_done) begin
                    state_next = ST_DIV_SLOT;
                end
            end
            ST_DIV_SLOT: begin
                state_next = ST_NEXT_RES;
            end
            ST_NEXT_RES: begin
                if (kind_has) begin
                    state_next = ST_ISSUE;
                end else if (kind_reg == KIND_SELF) begin
                    state_next = ST_FINISH;
                end
            end
            ST_ISSUE: begin
                if (nb_reg == 3'd7) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                state_next = (count_reg == '0) ? ST_OUT : ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = (kind_reg == KIND_SELF) ? ST_FINISH : ST_NEXT_RES;
                end
            end
            ST_FINISH: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs to ports, sample RAM and divider
    always_comb begin
        s_ready      = state_reg == ST_IDLE;
        ram_rd_en    = state_reg == ST_ISSUE;
        ram_rd_addr  = addr_e[ADDR_W-1:0];
        ram_wr_en    = state_reg == ST_FINISH;
        div_start    = 1'b0;
        div_dividend = DW'(sum_mag);
        div_divisor  = VW'(count_reg);
        case (state_reg)
            ST_PREP: begin
                div_start    = !track_ok_reg;
                div_dividend = DW'(pos_sat);
                div_divisor  = VW'(cols);
            end
            ST_DIV_POS: begin
                div_divisor  = VW'(cols);
            end
            ST_DIV_START: begin
                div_start = count_reg != '0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath and counters
    always_comb begin
        frame_columns_next = frame_columns_reg;
        frame_rows_next    = frame_rows_reg;
        arrived_next       = arrived_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        slot_next          = slot_reg;
        track_ok_next      = track_ok_reg;
        last_next          = last_reg;
        pix_next           = pix_reg;
        kind_next          = kind_reg;
        nb_next            = nb_reg;
        pipe_valid_next    = 1'b0;
        pipe_pix_next      = use_pix;
        sum_next           = sum_reg;
        count_next         = count_reg;
        neg_next           = neg_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_mean_next        = m_mean_reg;
        m_done_next        = m_done_reg;

        if (pipe_valid_reg) begin
            sum_next   = sum_reg + SUM_W'(sample);
            count_next = count_reg + 4'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pix_next = s_pixel_value;
                end
            end
            ST_PREP: begin
                last_next = last_pos;
                kind_next = KIND_UP_LEFT;
                if (!track_ok_reg) begin
                    arrived_next = pos_sat;
                end
            end
            ST_DIV_POS: begin
                if (div_done) begin
                    row_next = div_quot[RIDX_W-1:0];
                    col_next = div_rem[CIDX_W-1:0];
                end
            end
            ST_DIV_SLOT: begin
                slot_next = slot_fold[ADDR_W-1:0];
            end
            ST_NEXT_RES: begin
                if (kind_has) begin
                    nb_next    = 3'd0;
                    sum_next   = '0;
                    count_next = '0;
                end else if (kind_reg != KIND_SELF) begin
                    kind_next = res_kind_t'(kind_reg + 2'd1);
                end
            end
            ST_ISSUE: begin
                pipe_valid_next = nb_exists;
                nb_next         = nb_reg + 3'd1;
            end
            ST_DIV_START: begin
                neg_next = sum_reg[SUM_W-1];
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_mean_next  = mean_val;
                    m_done_next  = kind_reg == KIND_SELF;
                    if (kind_reg != KIND_SELF) begin
                        kind_next = res_kind_t'(kind_reg + 2'd1);
                    end
                end
            end
            ST_FINISH: begin
                track_ok_next = 1'b1;
                if (last_reg) begin
                    arrived_next = '0;
                    row_next     = '0;
                    col_next     = '0;
                    slot_next    = '0;
                end else begin
                    arrived_next = arrived_reg + POS_W'(1);
                    if (last_col) begin
                        col_next = '0;
                        row_next = row_reg + RIDX_W'(1);
                    end else begin
                        col_next = col_reg + CIDX_W'(1);
                    end
                    if (slot_reg == ADDR_W'(DEPTH - 1)) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                nb_next = nb_reg;
            end
        endcase

        if (cfg_we) begin
            // a size change mid-frame invalidates the running row/column/slot counters
            track_ok_next = track_ok_reg && (arrived_reg == '0);
            case (cfg_index)
                REG_FRAME_COLUMNS: frame_columns_next = cfg_wdata[CFG_COLS_W-1:0];
                REG_FRAME_ROWS:    frame_rows_next    = cfg_wdata[CFG_ROWS_W-1:0];
                default:           frame_rows_next    = frame_rows_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            frame_columns_reg <= FRAME_COLUMNS_RESET;
            frame_rows_reg    <= FRAME_ROWS_RESET;
            arrived_reg       <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            slot_reg          <= '0;
            track_ok_reg      <= 1'b1;
            last_reg          <= 1'b0;
            kind_reg          <= KIND_UP_LEFT;
            nb_reg            <= '0;
            pipe_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            frame_columns_reg <= frame_columns_next;
            frame_rows_reg    <= frame_rows_next;
            arrived_reg       <= arrived_next;
            row_reg           <= row_next;
            col_reg           <= col_next;
            slot_reg          <= slot_next;
            track_ok_reg      <= track_ok_next;
            last_reg          <= last_next;
            kind_reg          <= kind_next;
            nb_reg            <= nb_next;
            pipe_valid_reg    <= pipe_valid_next;
            m_valid_reg       <= m_valid_next;
        end
        slot_quo_reg <= slot_quo_next;
        pix_reg      <= pix_next;
        pipe_pix_reg <= pipe_pix_next;
        sum_reg      <= sum_next;
        count_reg    <= count_next;
        neg_reg      <= neg_next;
        m_mean_reg   <= m_mean_next;
        m_done_reg   <= m_done_next;
    end

    nms_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (pix_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    nms_divider #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (VW)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign m_valid          = m_valid_reg;
    assign m_neighbour_mean = m_mean_reg;
    assign m_frame_done     = m_done_reg;

endmodule

>>> sv/nms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 66,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/nms_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module nms_divider #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DIVISOR_W'(shifted - {1'b0, divisor});
            end else begin
                rem_next = shifted[DIVISOR_W-1:0];
            end
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
